@@ design/khfe_pkg.sv @@
// shared types, constants and helpers for the free energy accumulator
// no dependencies
package khfe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [63:0] MAG_POS_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MAG_NEG_MAX = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic signed [63:0] site_sum;
    logic [31:0]        density;
    logic [7:0]         multiplicity;
    logic               final_site;
  } khfe_entry_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } khfe_qstat_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? $signed(MAG_NEG_MAX) : $signed(MAG_POS_MAX);
    end
    return s[63:0];
  endfunction

endpackage

@@ design/khfe_front.sv @@
// front end: accepts grid points, forms the point term and the site sum
// depends on khfe_pkg; pushes closed sites into khfe_queue
module khfe_front
  import khfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_gamma_value,
  input  logic signed [31:0] in_direct_corr,
  input  logic signed [31:0] in_long_range_potential,
  input  logic [31:0]        in_site_density,
  input  logic [7:0]         in_site_multiplicity,
  input  logic               in_last_of_site,
  input  logic               in_last_of_all,
  input  khfe_qstat_t        qstat,
  output logic               push,
  output khfe_entry_t        push_entry
);

  logic signed [32:0] h_w;
  logic signed [32:0] cl_w;
  logic signed [65:0] hh_w;
  logic signed [65:0] hcl_w;
  logic signed [63:0] sq_w;
  logic signed [63:0] cross_w;
  logic               accept_w;
  logic [QCNT_W:0]    pend_w;

  logic               v1_r;
  logic signed [63:0] sq_r;
  logic signed [63:0] cross_r;
  logic signed [32:0] cl_r;
  logic               close1_r;
  logic               final1_r;
  logic [31:0]        dens1_r;
  logic [7:0]         mult1_r;

  logic               v2_r;
  logic signed [63:0] term_r;
  logic               close2_r;
  logic               final2_r;
  logic [31:0]        dens2_r;
  logic [7:0]         mult2_r;

  logic signed [63:0] site_acc_r;
  logic signed [63:0] site_sum_w;

  assign pend_w = {1'b0, qstat.count} + (QCNT_W+1)'(v1_r & close1_r)
                + (QCNT_W+1)'(v2_r & close2_r);
  assign in_stall = pend_w >= (QCNT_W+1)'(QDEPTH);
  assign accept_w = in_valid && !in_stall;

  always_comb begin
    h_w     = $signed({in_gamma_value[31], in_gamma_value})
            + $signed({in_direct_corr[31], in_direct_corr});
    cl_w    = $signed({in_direct_corr[31], in_direct_corr})
            + $signed({in_long_range_potential[31], in_long_range_potential});
    hh_w    = h_w * h_w;
    hcl_w   = h_w * cl_w;
    sq_w    = h_w[32] ? 64'(hh_w >>> (FRAC_BITS + 1)) : '0;
    cross_w = 64'(hcl_w >>> (FRAC_BITS + 1));
  end

  assign site_sum_w = sat_add64(site_acc_r, term_r);

  assign push                    = v2_r && close2_r;
  assign push_entry.site_sum     = site_sum_w;
  assign push_entry.density      = dens2_r;
  assign push_entry.multiplicity = mult2_r;
  assign push_entry.final_site   = final2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      site_acc_r <= '0;
    end else begin
      v1_r <= accept_w;
      v2_r <= v1_r;
      if (v2_r) begin
        site_acc_r <= close2_r ? '0 : site_sum_w;
      end
    end
    if (accept_w) begin
      sq_r     <= sq_w;
      cross_r  <= cross_w;
      cl_r     <= cl_w;
      close1_r <= in_last_of_site | in_last_of_all;
      final1_r <= in_last_of_all;
      dens1_r  <= in_site_density;
      mult1_r  <= in_site_multiplicity;
    end
    if (v1_r) begin
      term_r   <= sq_r - {{31{cl_r[32]}}, cl_r} - cross_r;
      close2_r <= close1_r;
      final2_r <= final1_r;
      dens2_r  <= dens1_r;
      mult2_r  <= mult1_r;
    end
  end

endmodule

@@ design/khfe_queue.sv @@
// short queue of closed sites between the front and back ends
// depends on khfe_pkg
module khfe_queue
  import khfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  khfe_entry_t push_entry,
  input  logic        pop,
  output khfe_entry_t pop_entry,
  output khfe_qstat_t qstat
);

  khfe_entry_t       mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign pop_entry   = mem_r[rd_ptr_r];
  assign qstat.count = count_r;
  assign qstat.empty = count_r == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> count_r < QCNT_W'(QDEPTH))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue pop while empty");
`endif

endmodule

@@ design/khfe_back.sv @@
// back end: scales each closed site sum and updates the running total
// depends on khfe_pkg; one shared 32x32 multiplier, four partial products per step
module khfe_back
  import khfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        thermal_energy,
  input  logic [31:0]        cell_volume,
  input  khfe_qstat_t        qstat,
  input  khfe_entry_t        pop_entry,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_site_sum,
  output logic signed [63:0] out_free_energy,
  output logic               out_final_res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROUND,
    ST_TOTAL,
    ST_EMIT
  } state_t;

  localparam logic [2:0]   CNT_LAST = 3'd4;
  localparam logic [1:0]   STEP_MULT = 2'd2;
  localparam logic [1:0]   STEP_LAST = 2'd3;
  localparam logic [127:0] RND_ADD = (128'd1 << FRAC_BITS) - 128'd1;

  state_t             state_r, state_nxt;
  logic [1:0]         step_r, step_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [63:0]        opa_r, opa_nxt;
  logic [63:0]        opb_r, opb_nxt;
  logic               neg_r, neg_nxt;
  logic [127:0]       acc_r, acc_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [1:0]         pshift_r, pshift_nxt;
  logic signed [63:0] site_r, site_nxt;
  logic [7:0]         mult_r, mult_nxt;
  logic               final_r, final_nxt;
  logic signed [63:0] total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [63:0] out_sum_r, out_sum_nxt;
  logic signed [63:0] out_fe_r, out_fe_nxt;
  logic               out_final_r, out_final_nxt;

  logic [31:0]        a_half_w;
  logic [31:0]        b_half_w;
  logic [127:0]       shifted_w;
  logic [127:0]       rnd_w;
  logic [127:0]       q_w;
  logic [63:0]        mag_w;
  logic               res_neg_w;
  logic [63:0]        site_mag_w;
  logic               emit_w;

  assign a_half_w = cnt_r[0] ? opa_r[63:32] : opa_r[31:0];
  assign b_half_w = cnt_r[1] ? opb_r[63:32] : opb_r[31:0];
  assign site_mag_w = site_r[63] ? 64'(-site_r) : site_r;
  assign emit_w = !out_valid_r || !out_stall;

  always_comb begin
    case (pshift_r)
      2'd0:    shifted_w = {64'd0, prod_r};
      2'd1:    shifted_w = {32'd0, prod_r, 32'd0};
      default: shifted_w = {prod_r, 64'd0};
    endcase
  end

  always_comb begin
    rnd_w     = acc_r + ((neg_r && step_r != STEP_MULT) ? RND_ADD : 128'd0);
    q_w       = (step_r == STEP_MULT) ? rnd_w : (rnd_w >> FRAC_BITS);
    mag_w     = (|q_w[127:63]) ? (neg_r ? MAG_NEG_MAX : MAG_POS_MAX) : q_w[63:0];
    res_neg_w = neg_r && (mag_w != '0);
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    pshift_nxt    = pshift_r;
    site_nxt      = site_r;
    mult_nxt      = mult_r;
    final_nxt     = final_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sum_nxt   = out_sum_r;
    out_fe_nxt    = out_fe_r;
    out_final_nxt = out_final_r;
    pop           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!qstat.empty) begin
          pop       = 1'b1;
          site_nxt  = pop_entry.site_sum;
          mult_nxt  = pop_entry.multiplicity;
          final_nxt = pop_entry.final_site;
          opa_nxt   = {32'd0, thermal_energy};
          opb_nxt   = {32'd0, pop_entry.density};
          neg_nxt   = 1'b0;
          step_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_r != CNT_LAST) begin
          prod_nxt   = a_half_w * b_half_w;
          pshift_nxt = {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
        end
        acc_nxt = (cnt_r == '0) ? '0 : acc_r + shifted_w;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_ROUND;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ROUND: begin
        opa_nxt  = mag_w;
        neg_nxt  = res_neg_w;
        cnt_nxt  = '0;
        step_nxt = step_r + 1'b1;
        case (step_r)
          2'd0: begin
            opb_nxt = site_mag_w;
            neg_nxt = site_r[63];
          end
          2'd1:    opb_nxt = {56'd0, mult_r};
          2'd2:    opb_nxt = {32'd0, cell_volume};
          default: opb_nxt = opb_r;
        endcase
        state_nxt = (step_r == STEP_LAST) ? ST_TOTAL : ST_MUL;
      end
      ST_TOTAL: begin
        total_nxt = sat_add64(total_r, neg_r ? $signed(64'(-opa_r)) : $signed(opa_r));
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_w) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = site_r;
          out_fe_nxt    = total_r;
          out_final_nxt = final_r;
          if (final_r) begin
            total_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    opa_r       <= opa_nxt;
    opb_r       <= opb_nxt;
    neg_r       <= neg_nxt;
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    pshift_r    <= pshift_nxt;
    site_r      <= site_nxt;
    mult_r      <= mult_nxt;
    final_r     <= final_nxt;
    out_sum_r   <= out_sum_nxt;
    out_fe_r    <= out_fe_nxt;
    out_final_r <= out_final_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_site_sum    = out_sum_r;
  assign out_free_energy = out_fe_r;
  assign out_final_res   = out_final_r;

`ifndef ASSERT_OFF
  a_total_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && emit_w && final_r |=> total_r == '0)
    else $error("total not cleared after final site");
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EMIT)
    else $error("result raised outside emit");
`endif

endmodule

@@ design/kh_free_energy_accumulator_core.sv @@
// free energy accumulator top level: config registers, front end, queue, back end
// depends on khfe_pkg, khfe_front, khfe_queue, khfe_back
//
// Input channel (in_*): one grid point per transaction, accepted when in_valid
// is high and in_stall low. Points stream in at one per cycle while in_stall
// stays low; the front end forms the point term over two pipeline stages and
// adds it to the site sum. A point with in_last_of_site or in_last_of_all
// closes its site and places the site sum in a four-entry queue. in_stall
// rises only when the queue and the points in flight could fill it.
// The back end scales one closed site at a time with a shared 32x32
// multiplier: four scaling steps of four partial products each. A closing
// point passes through the front end stages and the queue to the back end,
// which presents its result on the output channel (out_*).
// Output is registered; while out_stall is high the result holds and the
// back end waits, and the front end keeps accepting until the queue fills.
// After the final site the running total returns to zero.
// Synchronous reset clears both sums and sets both config registers to 1.0.
// Config via APB at paddr 0 (kT) and 4 (cell volume); write only when idle.
module kh_free_energy_accumulator_core
  import khfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_gamma_value,
  input  logic signed [31:0] in_direct_corr,
  input  logic signed [31:0] in_long_range_potential,
  input  logic [31:0]        in_site_density,
  input  logic [7:0]         in_site_multiplicity,
  input  logic               in_last_of_site,
  input  logic               in_last_of_all,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_site_sum,
  output logic signed [63:0] out_free_energy,
  output logic               out_final_res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0] kt_r;
  logic [31:0] vol_r;
  logic        wr_w;

  logic        push;
  khfe_entry_t push_entry;
  logic        pop;
  khfe_entry_t pop_entry;
  khfe_qstat_t qstat;

  assign pready = 1'b1;
  assign wr_w   = psel && penable && pwrite;
  assign prdata = paddr[2] ? vol_r : kt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kt_r  <= 32'd1 << FRAC_BITS;
      vol_r <= 32'd1 << FRAC_BITS;
    end else if (wr_w) begin
      if (paddr[2]) begin
        vol_r <= pwdata;
      end else begin
        kt_r <= pwdata;
      end
    end
  end

  khfe_front u_front (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_gamma_value          (in_gamma_value),
    .in_direct_corr          (in_direct_corr),
    .in_long_range_potential (in_long_range_potential),
    .in_site_density         (in_site_density),
    .in_site_multiplicity    (in_site_multiplicity),
    .in_last_of_site         (in_last_of_site),
    .in_last_of_all          (in_last_of_all),
    .qstat                   (qstat),
    .push                    (push),
    .push_entry              (push_entry)
  );

  khfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .qstat      (qstat)
  );

  khfe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .thermal_energy  (kt_r),
    .cell_volume     (vol_r),
    .qstat           (qstat),
    .pop_entry       (pop_entry),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_site_sum    (out_site_sum),
    .out_free_energy (out_free_energy),
    .out_final_res   (out_final_res)
  );

endmodule

@@ tb/kh_free_energy_accumulator_core_tb.sv @@
// testbench for kh_free_energy_accumulator_core: directed and random grid point streams
// checked against a fixed point model of the site sum and the running free energy
// depends on khfe_pkg and the design sources
`timescale 1ns / 1ps

module kh_free_energy_accumulator_core_tb
  import khfe_pkg::*;
();

  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          REG_THERMAL_ENERGY = 0;
  localparam int          REG_CELL_VOLUME    = 1;
  localparam logic [31:0] ONE    = 32'(1) << FRAC_BITS;
  localparam logic [31:0] W_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] W_MIN  = 32'h8000_0000;
  localparam logic [31:0] W_ONES = 32'hffff_ffff;
  localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [63:0] site_sum;
    logic signed [63:0] free_energy;
    logic               final_flag;
  } site_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_gamma_value = '0;
  logic signed [31:0] in_direct_corr = '0;
  logic signed [31:0] in_long_range_potential = '0;
  logic [31:0]        in_site_density = '0;
  logic [7:0]         in_site_multiplicity = '0;
  logic               in_last_of_site = 1'b0;
  logic               in_last_of_all = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [63:0] out_site_sum;
  logic signed [63:0] out_free_energy;
  logic               out_final_res;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  site_result_t       pending_site_results[$];
  logic signed [63:0] site_acc_model;
  logic signed [63:0] total_acc_model;
  logic [31:0]        kt_setting;
  logic [31:0]        volume_setting;
  int                 error_count = 0;
  int                 cycle_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;

  kh_free_energy_accumulator_core u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_gamma_value          (in_gamma_value),
    .in_direct_corr          (in_direct_corr),
    .in_long_range_potential (in_long_range_potential),
    .in_site_density         (in_site_density),
    .in_site_multiplicity    (in_site_multiplicity),
    .in_last_of_site         (in_last_of_site),
    .in_last_of_all          (in_last_of_all),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_site_sum            (out_site_sum),
    .out_free_energy         (out_free_energy),
    .out_final_res           (out_final_res),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // floor(a*b / 2^sh), clamped to the signed 64-bit range
  function automatic logic signed [63:0] floor_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input int sh);
    logic signed [127:0] p;
    p = a * b;
    p = p >>> sh;
    if (p[127:63] != {65{p[127]}}) begin
      return p[127] ? S64_MIN : S64_MAX;
    end
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] clamp_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = a + b;
    if (s > 65'(S64_MAX)) return S64_MAX;
    if (s < 65'(S64_MIN)) return S64_MIN;
    return s[63:0];
  endfunction

  task automatic accumulate_point(input logic signed [31:0] g, input logic signed [31:0] c,
                                  input logic signed [31:0] lr, input logic [31:0] dens,
                                  input logic [7:0] mult, input logic los, input logic loa);
    logic signed [63:0] h;
    logic signed [63:0] cl;
    logic signed [63:0] sq;
    logic signed [63:0] h_cl;
    logic signed [63:0] scaled;
    site_result_t       r;
    h = g;
    h = h + c;
    cl = c;
    cl = cl + lr;
    sq = (h < 0) ? floor_mul(h, h, FRAC_BITS + 1) : 64'sd0;
    h_cl = floor_mul(h, cl, FRAC_BITS + 1);
    site_acc_model = clamp_sum(site_acc_model,
                               clamp_sum(clamp_sum(sq, -cl),
                                         (h_cl == S64_MIN) ? S64_MAX : -h_cl));
    if (los || loa) begin
      scaled = floor_mul({32'b0, kt_setting}, {32'b0, dens}, FRAC_BITS);
      scaled = floor_mul(scaled, site_acc_model, FRAC_BITS);
      scaled = floor_mul(scaled, {56'b0, mult}, 0);
      scaled = floor_mul(scaled, {32'b0, volume_setting}, FRAC_BITS);
      total_acc_model = clamp_sum(total_acc_model, scaled);
      r.site_sum    = site_acc_model;
      r.free_energy = total_acc_model;
      r.final_flag  = loa;
      pending_site_results.push_back(r);
      site_acc_model = '0;
      if (loa) total_acc_model = '0;
    end
  endtask

  always @(negedge clk) begin
    site_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_site_results.size() == 0) begin
        $display("%0t unexpected result: site_sum %0d free_energy %0d final %0b", $time,
                 out_site_sum, out_free_energy, out_final_res);
        error_count++;
      end else begin
        exp_r = pending_site_results.pop_front();
        if (out_site_sum !== exp_r.site_sum) begin
          $display("%0t site_sum: expected %0d actual %0d", $time, exp_r.site_sum,
                   out_site_sum);
          error_count++;
        end
        if (out_free_energy !== exp_r.free_energy) begin
          $display("%0t free_energy: expected %0d actual %0d", $time, exp_r.free_energy,
                   out_free_energy);
          error_count++;
        end
        if (out_final_res !== exp_r.final_flag) begin
          $display("%0t final_res: expected %0b actual %0b", $time, exp_r.final_flag,
                   out_final_res);
          error_count++;
        end
      end
    end
  end

  task automatic send_point(input logic [31:0] g, input logic [31:0] c, input logic [31:0] lr,
                            input logic [31:0] dens, input logic [7:0] mult,
                            input logic los, input logic loa);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid                <= 1'b1;
    in_gamma_value          <= g;
    in_direct_corr          <= c;
    in_long_range_potential <= lr;
    in_site_density         <= dens;
    in_site_multiplicity    <= mult;
    in_last_of_site         <= los;
    in_last_of_all          <= loa;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    accumulate_point(g, c, lr, dens, mult, los, loa);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_site_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_THERMAL_ENERGY) kt_setting = value;
    else if (idx == REG_CELL_VOLUME) volume_setting = value;
    @(posedge clk);
  endtask

  task automatic read_reg(input int idx, input logic [31:0] expected);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 3'(4 * idx);
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    if (prdata !== expected) begin
      $display("%0t register %0d readback: expected %0h actual %0h", $time, idx, expected,
               prdata);
      error_count++;
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] kt, input logic [31:0] vol);
    wait_drained();
    write_reg(REG_THERMAL_ENERGY, kt);
    write_reg(REG_CELL_VOLUME, vol);
    read_reg(REG_THERMAL_ENERGY, kt);
    read_reg(REG_CELL_VOLUME, vol);
  endtask

  function automatic logic [31:0] rand_corr();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(4))
        0: return '0;
        1: return 32'd1;
        2: return W_MAX;
        3: return W_MIN;
        default: return W_ONES;
      endcase
    end
    if (pick < 30) return $urandom;
    return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
  endfunction

  function automatic logic [31:0] rand_density();
    if ($urandom_range(99) < 20) return $urandom;
    return 32'($urandom_range(0, 2 * ONE));
  endfunction

  function automatic logic [7:0] rand_mult();
    if ($urandom_range(99) < 60) return 8'($urandom_range(1, 4));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_register_access();
    read_reg(REG_THERMAL_ENERGY, ONE);
    read_reg(REG_CELL_VOLUME, ONE);
    set_config(W_ONES, '0);
    set_config('0, W_ONES);
    set_config(ONE, ONE);
  endtask

  task automatic test_directed_points();
    send_point('0, '0, '0, ONE, 8'd1, 1'b1, 1'b0);
    send_point(W_MAX, W_MAX, W_MAX, W_ONES, 8'd255, 1'b1, 1'b0);
    send_point(W_MIN, W_MIN, W_MIN, W_ONES, 8'd255, 1'b1, 1'b0);
    send_point(W_MIN, W_MAX, W_MIN, ONE, 8'd1, 1'b1, 1'b0);
    // three point site, negative h at every point
    send_point(-ONE, ONE / 2, ONE / 4, ONE, 8'd2, 1'b0, 1'b0);
    send_point(ONE, -(2 * ONE), ONE, ONE, 8'd2, 1'b0, 1'b0);
    send_point(-(3 * ONE), ONE, -ONE, ONE, 8'd2, 1'b1, 1'b0);
    // end of computation without the site flag
    send_point(ONE, ONE, '0, 2 * ONE, 8'd1, 1'b0, 1'b1);
    send_point(-ONE, '0, '0, ONE, 8'd1, 1'b1, 1'b1);
    send_point(ONE, ONE, ONE, '0, 8'd0, 1'b1, 1'b0);
    // drive the running total into saturation and back
    send_point(W_MIN, W_MIN, W_MAX, W_ONES, 8'd255, 1'b1, 1'b0);
    send_point(W_MIN, W_MIN, W_MAX, W_ONES, 8'd255, 1'b1, 1'b0);
    send_point(W_MAX, W_MAX, W_MIN, W_ONES, 8'd255, 1'b1, 1'b0);
    send_point('0, '0, '0, ONE, 8'd1, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    set_config(W_ONES, W_ONES);
    send_point(-ONE, ONE / 2, ONE, ONE, 8'd3, 1'b1, 1'b0);
    send_point(W_MIN, W_MIN, W_MIN, W_ONES, 8'd255, 1'b1, 1'b1);
    set_config('0, '0);
    send_point(ONE, -ONE, ONE, W_ONES, 8'd255, 1'b1, 1'b0);
    send_point(ONE, ONE, ONE, ONE, 8'd1, 1'b0, 1'b1);
    set_config(W_ONES, '0);
    send_point(W_MAX, W_MIN, W_MAX, W_ONES, 8'd7, 1'b1, 1'b1);
    set_config('0, W_ONES);
    send_point(-(2 * ONE), ONE, '0, W_ONES, 8'd9, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic run_random_stream(input int n_items);
    int          count;
    int          n_sites;
    int          len;
    logic [31:0] dens;
    logic [7:0]  mult;
    logic        end_site;
    logic        end_all;
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_point($urandom, $urandom, $urandom, $urandom, 8'($urandom),
                   ($urandom_range(3) == 0), ($urandom_range(15) == 0));
        count++;
      end else begin
        n_sites = $urandom_range(1, 6);
        for (int s = 0; s < n_sites; s++) begin
          len  = $urandom_range(1, 10);
          dens = rand_density();
          mult = rand_mult();
          for (int p = 0; p < len; p++) begin
            end_all  = (p == len - 1) && (s == n_sites - 1) && ($urandom_range(99) < 90);
            end_site = (p == len - 1) && (end_all ? $urandom_range(1) : 1'b1);
            send_point(rand_corr(), rand_corr(), rand_corr(), dens, mult, end_site, end_all);
            count++;
          end
        end
      end
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct  = 12;
    recv_stall_pct = 60;
    set_config(32'($urandom_range(ONE / 2, 2 * ONE)), 32'($urandom_range(1, ONE)));
    run_random_stream(300);
    send_idle_pct  = 60;
    recv_stall_pct = 12;
    set_config(W_ONES, 32'd1);
    run_random_stream(300);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config($urandom, $urandom);
    run_random_stream(300);
  endtask

  initial begin
    site_acc_model  = '0;
    total_acc_model = '0;
    kt_setting      = ONE;
    volume_setting  = ONE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct  = 12;
    recv_stall_pct = 60;
    test_register_access();
    test_directed_points();
    test_config_extremes();
    test_random_traffic();
    wait_drained();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
